### design/egcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared constants for the extended gcd block and its step unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

    // Default operand width in bits
    localparam int EGCD_DATA_WIDTH = 32;

endpackage
`default_nettype wire

### design/egcd_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_step_unit
// Restoring unsigned divider, one quotient bit per cycle, that folds each
// quotient bit into two multiply accumulators (Horner form, MSB first) so
// that |q|*s and |q|*t modulo 2^DATA_WIDTH are ready with the remainder.
// ----------------------------------------------------------------------------
module egcd_step_unit #(
    parameter int DATA_WIDTH = egcd_pkg::EGCD_DATA_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    input  wire logic [DATA_WIDTH-1:0] s_mult,
    input  wire logic [DATA_WIDTH-1:0] t_mult,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      remainder,
    output logic [DATA_WIDTH-1:0]      s_prod,
    output logic [DATA_WIDTH-1:0]      t_prod
);
    import egcd_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] s_mul_reg;
    logic [DW-1:0] t_mul_reg;
    logic [DW-1:0] s_acc_reg;
    logic [DW-1:0] t_acc_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          q_bit;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] s_acc_next;
    logic [DW-1:0] t_acc_next;
    logic          last_iter;

    always_comb
    begin
        trial      = {rem_reg, num_reg[DW-1]};
        diff       = trial - {1'b0, den_reg};
        q_bit      = (trial >= {1'b0, den_reg});
        rem_next   = q_bit ? diff[DW-1:0] : trial[DW-1:0];
        s_acc_next = {s_acc_reg[DW-2:0], 1'b0} + (q_bit ? s_mul_reg : '0);
        t_acc_next = {t_acc_reg[DW-2:0], 1'b0} + (q_bit ? t_mul_reg : '0);
        last_iter  = (count_reg == CW'(DW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= dividend;
            den_reg   <= divisor;
            rem_reg   <= '0;
            s_mul_reg <= s_mult;
            t_mul_reg <= t_mult;
            s_acc_reg <= '0;
            t_acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, fold the quotient bit in
            num_reg   <= {num_reg[DW-2:0], 1'b0};
            rem_reg   <= rem_next;
            s_acc_reg <= s_acc_next;
            t_acc_reg <= t_acc_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign s_prod    = s_acc_reg;
    assign t_prod    = t_acc_reg;

endmodule
`default_nettype wire

### design/extended_gcd_and_inverse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_and_inverse
// Extended Euclidean gcd with Bezout coefficients, or inverse form.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transfer carries operands a and b in s_tdata and
//   the mode in s_tuser (0 = gcd with both coefficients, 1 = inverse form:
//   coefficient of a negated when the gcd is negative, coefficient of b 0).
//   Master channel m_*: one transfer per input with gcd_value, coeff_a and
//   coeff_b. Division is truncating and signed; results wrap to DATA_WIDTH.
//   Sequence: each Euclid step starts the shared divide/multiply unit from
//   ST_CHECK and waits for it in ST_DIV; an item passes ST_CHECK once per
//   step and once more before ST_FINISH, steps being the number of nonzero
//   remainders (up to about 46 for 32-bit operands).
//   s_tready is high only while the sequencer is idle; one item is worked on
//   at a time.
//   The result sits in an output register; a stalled receiver holds it, and
//   the block still takes the next item and runs it, waiting only before
//   writing the following result.
//   Reset clears the sequencer and m_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module extended_gcd_and_inverse #(
    parameter int DATA_WIDTH = egcd_pkg::EGCD_DATA_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // a, b (zero padded to whole bytes)
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
    // mode
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // gcd_value, coeff_a, coeff_b (zero padded to whole bytes)
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]         m_tdata
);
    import egcd_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = ((3*DW+7)/8)*8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    logic                 mode_reg;
    logic signed [DW-1:0] r_prev_reg;
    logic signed [DW-1:0] r_cur_reg;
    logic [DW-1:0]        s_prev_reg;
    logic [DW-1:0]        s_cur_reg;
    logic [DW-1:0]        t_prev_reg;
    logic [DW-1:0]        t_cur_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              step_start;
    logic              step_done;
    logic [DW-1:0]     prev_mag;
    logic [DW-1:0]     cur_mag;
    logic [DW-1:0]     rem_mag;
    logic [DW-1:0]     s_prod;
    logic [DW-1:0]     t_prod;
    logic              q_neg;
    logic [DW-1:0]     r_next;
    logic [DW-1:0]     s_next;
    logic [DW-1:0]     t_next;
    logic [DW-1:0]     coeff_a;
    logic [DW-1:0]     coeff_b;
    logic [OUT_W-1:0]  m_tdata_next;

    assign in_accept  = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == ST_FINISH) && out_free;
    assign step_start = (state_reg == ST_CHECK) && (r_cur_reg != '0);

    always_comb
    begin
        prev_mag = r_prev_reg[DW-1] ? (~r_prev_reg + 1'b1) : r_prev_reg;
        cur_mag  = r_cur_reg[DW-1] ? (~r_cur_reg + 1'b1) : r_cur_reg;
        // quotient sign follows the operand signs, remainder the dividend
        q_neg    = r_prev_reg[DW-1] ^ r_cur_reg[DW-1];
        r_next   = r_prev_reg[DW-1] ? (~rem_mag + 1'b1) : rem_mag;
        s_next   = q_neg ? (s_prev_reg + s_prod) : (s_prev_reg - s_prod);
        t_next   = q_neg ? (t_prev_reg + t_prod) : (t_prev_reg - t_prod);

        coeff_a  = (mode_reg && r_prev_reg[DW-1]) ? (~s_prev_reg + 1'b1) : s_prev_reg;
        coeff_b  = mode_reg ? '0 : t_prev_reg;

        m_tdata_next              = '0;
        m_tdata_next[DW-1:0]      = r_prev_reg;
        m_tdata_next[2*DW-1:DW]   = coeff_a;
        m_tdata_next[3*DW-1:2*DW] = coeff_b;
    end

    egcd_step_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (step_start),
        .dividend  (prev_mag),
        .divisor   (cur_mag),
        .s_mult    (s_cur_reg),
        .t_mult    (t_cur_reg),
        .done      (step_done),
        .remainder (rem_mag),
        .s_prod    (s_prod),
        .t_prod    (t_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (out_load)
                m_tvalid_reg <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (r_cur_reg == '0)
                        state_reg <= ST_FINISH;
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_done)
                        state_reg <= ST_CHECK;
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= s_tuser;
            r_prev_reg <= s_tdata[DW-1:0];
            r_cur_reg  <= s_tdata[2*DW-1:DW];
            s_prev_reg <= DW'(1);
            s_cur_reg  <= '0;
            t_prev_reg <= '0;
            t_cur_reg  <= DW'(1);
        end
        else if ((state_reg == ST_DIV) && step_done)
        begin
            // advance the remainder and coefficient sequences
            r_prev_reg <= r_cur_reg;
            r_cur_reg  <= r_next;
            s_prev_reg <= s_cur_reg;
            s_cur_reg  <= s_next;
            t_prev_reg <= t_cur_reg;
            t_cur_reg  <= t_next;
        end

        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### design/egcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks for the extended gcd block, bound to the top level.
// ----------------------------------------------------------------------------
module egcd_checker #(
    parameter int DATA_WIDTH = egcd_pkg::EGCD_DATA_WIDTH
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata
);
    import egcd_pkg::*;

    // a pending result stays until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

    // one item at a time: no new transfer right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("s_tready high right after an input transfer");

    // a result needs at least the check and finish cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result raised one cycle after input transfer");

    // nothing is announced out of reset
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
    else $error("m_tvalid high after reset");

endmodule

bind extended_gcd_and_inverse egcd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_egcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for extended_gcd_and_inverse. Operand pairs go in over
// the slave stream, each result from the master stream is checked field by
// field against a local model of the extended Euclidean loop (truncating
// signed division, coefficients kept at 64 bits and wrapped on output).
// Directed corners first, then random operand classes, modular inverses, a
// long receiver hold-off, a drain pause and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb;

    localparam int DW           = egcd_pkg::EGCD_DATA_WIDTH;
    localparam int SW           = ((2*DW+7)/8)*8;
    localparam int MW           = ((3*DW+7)/8)*8;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 6000;
    localparam int TAIL_CYCLES  = 100;

    localparam logic signed [DW-1:0] S_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] S_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_ONE  = 1;
    localparam logic signed [DW-1:0] S_NEG1 = -1;
    localparam logic signed [DW-1:0] S_ZERO = 0;

    typedef enum logic {MODE_GCD = 1'b0, MODE_INV = 1'b1} egcd_mode_t;

    // gcd_value sits in the lowest bits
    typedef struct packed {
        logic signed [DW-1:0] coeff_b;
        logic signed [DW-1:0] coeff_a;
        logic signed [DW-1:0] gcd_value;
    } egcd_result_t;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata  = '0;   // a, b
    logic          s_tuser  = 1'b0; // mode
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;         // gcd_value, coeff_a, coeff_b

    egcd_result_t pending_gcd_q[$];
    int unsigned  error_count   = 0;
    logic         tx_idle_en    = 1'b1;
    logic         rx_idle_en    = 1'b1;
    int unsigned  hold_requests = 0;
    int unsigned  hold_served   = 0;
    int unsigned  hold_left     = 0;
    int unsigned  stall_left    = 0;

    extended_gcd_and_inverse #(
        .DATA_WIDTH (DW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    // Extended Euclid with truncating division; coefficients wrap mod 2^64
    function automatic egcd_result_t egcd_predict(egcd_mode_t mode,
                                                  logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
        longint       r_prev;
        longint       r_cur;
        longint       q;
        longint       r_next;
        logic [63:0]  qu;
        logic [63:0]  s_prev;
        logic [63:0]  s_cur;
        logic [63:0]  s_next;
        logic [63:0]  t_prev;
        logic [63:0]  t_cur;
        logic [63:0]  t_next;
        logic [63:0]  ca;
        egcd_result_t res;
        r_prev = a;
        r_cur  = b;
        s_prev = 64'd1;
        s_cur  = 64'd0;
        t_prev = 64'd0;
        t_cur  = 64'd1;
        while (r_cur != 0)
        begin
            q      = r_prev / r_cur;
            r_next = r_prev % r_cur;
            qu     = q;
            s_next = s_prev - qu * s_cur;
            t_next = t_prev - qu * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        res.gcd_value = r_prev[DW-1:0];
        if (mode == MODE_INV)
        begin
            ca = (r_prev < 0) ? (64'd0 - s_prev) : s_prev;
            res.coeff_a = ca[DW-1:0];
            res.coeff_b = '0;
        end
        else
        begin
            res.coeff_a = s_prev[DW-1:0];
            res.coeff_b = t_prev[DW-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        egcd_result_t got;
        egcd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[3*DW-1:0];
            if (pending_gcd_q.size() == 0)
            begin
                $display("tb: result %h with nothing pending at %0t", got, $realtime);
                error_count++;
            end
            else
            begin
                want = pending_gcd_q.pop_front();
                if (got.gcd_value !== want.gcd_value)
                    report_mismatch("gcd_value", got.gcd_value, want.gcd_value);
                if (got.coeff_a !== want.coeff_a)
                    report_mismatch("coeff_a", got.coeff_a, want.coeff_a);
                if (got.coeff_b !== want.coeff_b)
                    report_mismatch("coeff_b", got.coeff_b, want.coeff_b);
            end
        end
    end

    task automatic send_operands(egcd_mode_t mode, logic signed [DW-1:0] a,
                                 logic signed [DW-1:0] b);
        int unsigned gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SW'({b, a});
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_gcd_q.push_back(egcd_predict(mode, a, b));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_gcd_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Mix of operand classes; consecutive Fibonacci pairs give the longest runs
    task automatic pick_pair(output logic signed [DW-1:0] a, output logic signed [DW-1:0] b);
        longint      f0;
        longint      f1;
        longint      f2;
        int unsigned k;
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel < 7)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (sel < 10)
        begin
            a = $signed($urandom_range(0, 511)) - 256;
            b = $signed($urandom_range(0, 511)) - 256;
        end
        else if (sel == 10)
        begin
            a = $urandom;
            b = S_ZERO;
        end
        else if (sel == 11)
        begin
            a = ($urandom_range(0, 1) == 0) ? S_MIN : S_MAX;
            b = ($urandom_range(0, 1) == 0) ? S_NEG1 : $urandom;
        end
        else if (sel < 14)
        begin
            k  = $urandom_range(1, 44);
            f0 = 0;
            f1 = 1;
            repeat (k)
            begin
                f2 = f0 + f1;
                f0 = f1;
                f1 = f2;
            end
            a = ($urandom_range(0, 1) == 0) ? DW'(f1) : DW'(-f1);
            b = ($urandom_range(0, 1) == 0) ? DW'(f0) : DW'(-f0);
        end
        else
        begin
            a = S_ONE <<< $urandom_range(0, DW-1);
            b = ($urandom_range(0, 1) == 0) ? S_ZERO - a : $urandom;
        end
    endtask

    task automatic test_directed();
        send_operands(MODE_GCD, S_ZERO, S_ZERO);
        send_operands(MODE_INV, S_ZERO, S_ZERO);
        send_operands(MODE_GCD, 12345, S_ZERO);
        send_operands(MODE_INV, -12345, S_ZERO);
        send_operands(MODE_GCD, -12345, S_ZERO);
        send_operands(MODE_INV, S_MIN, S_ZERO);
        send_operands(MODE_GCD, S_MIN, S_NEG1);
        send_operands(MODE_INV, S_MIN, S_NEG1);
        send_operands(MODE_GCD, S_MIN, S_MIN);
        send_operands(MODE_GCD, S_MAX, S_MAX);
        send_operands(MODE_GCD, S_MAX, S_MIN);
        send_operands(MODE_INV, S_MIN, S_MAX);
        send_operands(MODE_GCD, S_ZERO, 5);
        send_operands(MODE_INV, S_ZERO, -5);
        send_operands(MODE_INV, -7, 3);
        send_operands(MODE_GCD, 240, 46);
        send_operands(MODE_INV, -240, 46);
        send_operands(MODE_GCD, 46, -240);
        send_operands(MODE_GCD, 1836311903, 1134903170);
        send_operands(MODE_INV, -1836311903, 1134903170);
        send_operands(MODE_GCD, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_operands(MODE_INV, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_operands(MODE_GCD, S_NEG1, S_ONE);
        send_operands(MODE_INV, 17, 3120);
    endtask

    task automatic test_random_operands(int unsigned count);
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        repeat (count)
        begin
            pick_pair(a, b);
            send_operands(egcd_mode_t'($urandom_range(0, 1)), a, b);
        end
    endtask

    // Inverse form against an odd positive modulus
    task automatic test_modular_inverse(int unsigned count);
        logic signed [DW-1:0] m;
        logic signed [DW-1:0] a;
        repeat (count)
        begin
            m = $urandom_range(3, 32'h7FFF_FFFF) | 1;
            a = $urandom % m;
            if ($urandom_range(0, 3) == 0)
                a = -a;
            send_operands(MODE_INV, a, m);
        end
    endtask

    // Receiver holds off long enough that the input side has to stall
    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        test_random_operands(8);
    endtask

    task automatic test_drain_pause();
        test_random_operands(10);
        wait_drained();
        test_random_operands(10);
    endtask

    task automatic test_no_idle();
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        wait_drained();
        test_random_operands(40);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_operands(240);
        test_modular_inverse(40);
        test_output_backpressure();
        test_drain_pause();
        test_no_idle();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
